// ===== rtl/edge_aware_box_filter_3x3_macros.svh =====
// ----------------------------------------------------------------------
// Edge-aware 3x3 box filter assertion macros
// Concurrent assertion helpers shared by the filter RTL. Defining
// NO_ASSERTIONS turns every helper into an empty statement.
// ----------------------------------------------------------------------
`ifndef EDGE_AWARE_BOX_FILTER_3X3_MACROS_SVH
`define EDGE_AWARE_BOX_FILTER_3X3_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is high.
`define EABF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("eabf: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define EABF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("eabf: assertion failed");

`else

`define EABF_ASSERT_IMP(label, clk, rst, ante, cons)
`define EABF_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/eabf_pkg.sv =====
// ----------------------------------------------------------------------
// Edge-aware 3x3 box filter package
// Field widths, register indexes, reset values and the reciprocal table
// used to divide the window sum by the in-bounds sample count.
// ----------------------------------------------------------------------
package eabf_pkg;

   // Payload and register widths.
   localparam int SAMPLE_W      = 16;
   localparam int GRID_WIDTH_W  = 13;
   localparam int GRID_HEIGHT_W = 16;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 16;

   // Default line store depth.
   localparam int MAX_WIDTH_DEFAULT = 4096;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_HEIGHT = 1'b1;

   // Register reset values.
   localparam logic [GRID_WIDTH_W-1:0]  GRID_WIDTH_RESET  = 13'd4096;
   localparam logic [GRID_HEIGHT_W-1:0] GRID_HEIGHT_RESET = 16'd4096;

   // Datapath widths: a column of three samples, nine samples, and the
   // rounding numerator 2*sum+count.
   localparam int COLSUM_W    = SAMPLE_W + 2;
   localparam int SUM_W       = SAMPLE_W + 4;
   localparam int NUM_W       = SUM_W + 1;
   localparam int COUNT_W     = 4;
   localparam int RECIP_SHIFT = 26;
   localparam int RECIP_W     = RECIP_SHIFT;
   localparam int PROD_W      = NUM_W + RECIP_W;

   // Which window neighbors are inside the grid, and the end-of-frame flag.
   typedef struct packed {
      logic top_ok;
      logic bottom_ok;
      logic left_ok;
      logic right_ok;
      logic last;
   } edge_info_type;

   // Rounded up 2^26 / (2*count). With a numerator below 2^21 the
   // truncated product equals the exact floor of numerator / (2*count).
   function automatic logic [RECIP_W-1:0] recip_of_count(input logic [COUNT_W-1:0] count);
      logic [RECIP_W-1:0] m;
      case (count)
         4'd1:    m = 26'd33554432;
         4'd2:    m = 26'd16777216;
         4'd3:    m = 26'd11184811;
         4'd4:    m = 26'd8388608;
         4'd6:    m = 26'd5592406;
         4'd9:    m = 26'd3728271;
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

// ===== rtl/eabf_if.sv =====
// ----------------------------------------------------------------------
// Edge-aware 3x3 box filter channels
// Valid/ready channels for sample words in and smoothed words out.
// ----------------------------------------------------------------------
interface eabf_req_if;
   logic                          valid;
   logic                          ready;
   logic [eabf_pkg::SAMPLE_W-1:0] height_sample;
   logic                          drain;

   modport source (output valid, output height_sample, output drain, input ready);
   modport sink (input valid, input height_sample, input drain, output ready);
endinterface

interface eabf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [eabf_pkg::SAMPLE_W-1:0] smoothed_height;
   logic                          frame_last;

   modport source (output valid, output smoothed_height, output frame_last, input ready);
   modport sink (input valid, input smoothed_height, input frame_last, output ready);
endinterface

// ===== rtl/edge_aware_box_filter_3x3.sv =====
// ----------------------------------------------------------------------
// Edge-aware 3x3 box filter
// Smooths a height grid streamed in raster order with the rounded mean of
// each point's in-bounds 3x3 neighborhood. Two line stores hold the two
// previous rows; results trail the input by one row and one sample.
// ----------------------------------------------------------------------
//
//  Channel    Direction  Word contents
//  req_chan   in         height_sample[15:0], drain
//  rsp_chan   out        smoothed_height[15:0], frame_last
//  csr_*      in         write enable, index, 16-bit data
//
// One word is taken per clock while the pipeline is not frozen; a result
// moves through the stage registers into the output register. The rate
// is set by the line store read-modify-write, with a forward path when
// one column is hit twice in a row. The pipeline freezes only while a
// finished result in its last stage meets an output register that is full
// and not being taken. Reset is synchronous; the line stores are not cleared.
//
`include "edge_aware_box_filter_3x3_macros.svh"

module edge_aware_box_filter_3x3 #(
   parameter int MAX_WIDTH = eabf_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   eabf_req_if.sink                           req_chan,
   eabf_rsp_if.source                         rsp_chan,
   input  logic                               csr_write_enable,
   input  logic [eabf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [eabf_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int EW = CW + 1;
   localparam int SW = eabf_pkg::SAMPLE_W;
   localparam int HW = eabf_pkg::GRID_HEIGHT_W;

   // Configuration registers.
   logic [eabf_pkg::GRID_WIDTH_W-1:0]  grid_width_ff;
   logic [HW-1:0]                      grid_height_ff;

   // Frame position counters.
   logic [CW-1:0] in_column_ff, in_column_in;
   logic [HW-1:0] in_row_ff, in_row_in;
   logic [CW-1:0] out_column_ff, out_column_in;
   logic [HW-1:0] out_row_ff, out_row_in;
   logic          primed_ff, primed_in;

   // Accept stage decode.
   logic                    advance;
   logic                    accept;
   logic                    take;
   logic                    emit_now;
   logic                    col_wrap;
   logic                    in_phase;
   logic [SW-1:0]           shift_sample;
   logic [EW-1:0]           w_eff;
   logic [HW-1:0]           h_eff;
   eabf_pkg::edge_info_type edge_now;

   // Line stores and their read data.
   logic [SW-1:0] older_row_mem [MAX_WIDTH];
   logic [SW-1:0] newer_row_mem [MAX_WIDTH];
   logic [SW-1:0] older_rd_ff;
   logic [SW-1:0] newer_rd_ff;

   // Stage 1: line store data back, window shift and write-back.
   logic                    s1_valid_ff;
   logic                    s1_emit_ff;
   logic [CW-1:0]           s1_idx_ff;
   logic [SW-1:0]           s1_sample_ff;
   eabf_pkg::edge_info_type s1_edge_ff;
   logic                    fwd_ff;
   logic [SW-1:0]           fwd_top_ff;
   logic [SW-1:0]           fwd_mid_ff;
   logic [SW-1:0]           s1_top;
   logic [SW-1:0]           s1_mid;

   // Window: [column, 0 is newest][row, 0 is top].
   logic [SW-1:0] win_ff [3][3];

   // Stage 2: column sums.
   logic                          s2_valid_ff;
   eabf_pkg::edge_info_type       s2_edge_ff;
   logic [eabf_pkg::COLSUM_W-1:0] colsum [3];

   // Stage 3: window sum and count.
   logic                          s3_valid_ff;
   eabf_pkg::edge_info_type       s3_edge_ff;
   logic [eabf_pkg::COLSUM_W-1:0] colsum_ff [3];
   logic [eabf_pkg::SUM_W-1:0]    sum;
   logic [1:0]                    rows;
   logic [1:0]                    cols;
   logic [eabf_pkg::COUNT_W-1:0]  count;
   logic [eabf_pkg::NUM_W-1:0]    num;

   // Stage 4: reciprocal multiply.
   logic                          s4_valid_ff;
   logic                          s4_last_ff;
   logic [eabf_pkg::NUM_W-1:0]    n_ff;
   logic [eabf_pkg::RECIP_W-1:0]  m_ff;
   logic [eabf_pkg::PROD_W-1:0]   product;

   // Output register.
   logic          rsp_valid_ff;
   logic [SW-1:0] rsp_height_ff;
   logic          rsp_last_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= eabf_pkg::GRID_WIDTH_RESET;
         grid_height_ff <= eabf_pkg::GRID_HEIGHT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            eabf_pkg::CSR_GRID_WIDTH: begin
               grid_width_ff <= csr_write_data[eabf_pkg::GRID_WIDTH_W-1:0];
            end
            eabf_pkg::CSR_GRID_HEIGHT: begin
               grid_height_ff <= csr_write_data[HW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Effective geometry: zero acts as one, width is capped by the store depth.
   always_comb begin
      if (grid_width_ff == '0) begin
         w_eff = EW'(1);
      end else if (32'(grid_width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = EW'(MAX_WIDTH);
      end else begin
         w_eff = EW'(grid_width_ff);
      end
      h_eff = (grid_height_ff == '0) ? HW'(1) : grid_height_ff;
   end

   // The pipeline moves unless a result in the last stage has nowhere to go.
   assign advance        = !(s4_valid_ff && rsp_valid_ff && !rsp_chan.ready);
   assign req_chan.ready = advance;
   assign accept         = req_chan.valid && advance;

   // Neighbor masks for the next result position.
   always_comb begin
      edge_now.top_ok    = out_row_ff != '0;
      edge_now.bottom_ok = ((HW + 1)'(out_row_ff) + (HW + 1)'(1)) < (HW + 1)'(h_eff);
      edge_now.left_ok   = out_column_ff != '0;
      edge_now.right_ok  = ({1'b0, out_column_ff} + EW'(1)) < w_eff;
      edge_now.last      = !edge_now.bottom_ok && !edge_now.right_ok;
   end

   // Accept stage: decide whether the word shifts the window and whether a
   // result falls due, and step the frame counters.
   always_comb begin
      in_column_in  = in_column_ff;
      in_row_in     = in_row_ff;
      out_column_in = out_column_ff;
      out_row_in    = out_row_ff;
      primed_in     = primed_ff;
      take          = 1'b0;
      emit_now      = 1'b0;
      shift_sample  = req_chan.height_sample;
      col_wrap      = ({1'b0, in_column_ff} + EW'(1)) >= w_eff;
      in_phase      = in_row_ff < h_eff;

      if (in_phase) begin
         if (!req_chan.drain) begin
            take     = 1'b1;
            emit_now = primed_ff;
            if (in_row_ff != '0) begin
               primed_in = 1'b1;
            end
            if (col_wrap) begin
               in_column_in = '0;
               in_row_in    = in_row_ff + HW'(1);
            end else begin
               in_column_in = in_column_ff + CW'(1);
            end
         end
      end else if (req_chan.drain) begin
         // Drain words push a zero row through the window.
         take         = 1'b1;
         shift_sample = '0;
         in_column_in = col_wrap ? '0 : in_column_ff + CW'(1);
         if (!primed_ff) begin
            primed_in = 1'b1;
         end else begin
            emit_now = 1'b1;
         end
      end

      if (emit_now) begin
         if (edge_now.last) begin
            in_column_in  = '0;
            in_row_in     = '0;
            out_column_in = '0;
            out_row_in    = '0;
            primed_in     = 1'b0;
         end else if (!edge_now.right_ok) begin
            out_column_in = '0;
            out_row_in    = out_row_ff + HW'(1);
         end else begin
            out_column_in = out_column_ff + CW'(1);
         end
      end
   end

   // Frame counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_column_ff  <= '0;
         in_row_ff     <= '0;
         out_column_ff <= '0;
         out_row_ff    <= '0;
         primed_ff     <= 1'b0;
      end else if (accept) begin
         in_column_ff  <= in_column_in;
         in_row_ff     <= in_row_in;
         out_column_ff <= out_column_in;
         out_row_ff    <= out_row_in;
         primed_ff     <= primed_in;
      end
   end

   // Older row store: read at accept, write back the middle row in stage 1.
   always_ff @(posedge clock) begin
      if (accept && take) begin
         older_rd_ff <= older_row_mem[in_column_ff];
      end
      if (advance && s1_valid_ff) begin
         older_row_mem[s1_idx_ff] <= s1_mid;
      end
   end

   // Newer row store: read at accept, write back the incoming sample.
   always_ff @(posedge clock) begin
      if (accept && take) begin
         newer_rd_ff <= newer_row_mem[in_column_ff];
      end
      if (advance && s1_valid_ff) begin
         newer_row_mem[s1_idx_ff] <= s1_sample_ff;
      end
   end

   // Stage 1 control.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_emit_ff  <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_chan.valid && take;
         s1_emit_ff  <= req_chan.valid && take && emit_now;
      end
   end

   // Stage 1 payload. When the word in stage 1 writes the same column that
   // is read now, its write data replaces the stale read.
   always_ff @(posedge clock) begin
      if (accept && take) begin
         s1_idx_ff    <= in_column_ff;
         s1_sample_ff <= shift_sample;
         s1_edge_ff   <= edge_now;
         fwd_ff       <= s1_valid_ff && (s1_idx_ff == in_column_ff);
         fwd_top_ff   <= s1_mid;
         fwd_mid_ff   <= s1_sample_ff;
      end
   end

   assign s1_top = fwd_ff ? fwd_top_ff : older_rd_ff;
   assign s1_mid = fwd_ff ? fwd_mid_ff : newer_rd_ff;

   // Window shift: new column enters at column 0.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
               win_ff[c][r] <= '0;
            end
         end
      end else if (advance && s1_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[2][r] <= win_ff[1][r];
            win_ff[1][r] <= win_ff[0][r];
         end
         win_ff[0][0] <= s1_top;
         win_ff[0][1] <= s1_mid;
         win_ff[0][2] <= s1_sample_ff;
      end
   end

   // Stage 2: masked column sums over the rows inside the grid.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         colsum[c] = eabf_pkg::COLSUM_W'(win_ff[c][1])
                   + (s2_edge_ff.top_ok ? eabf_pkg::COLSUM_W'(win_ff[c][0]) : '0)
                   + (s2_edge_ff.bottom_ok ? eabf_pkg::COLSUM_W'(win_ff[c][2]) : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_emit_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_edge_ff <= s1_edge_ff;
         s3_edge_ff <= s2_edge_ff;
         for (int c = 0; c < 3; c++) begin
            colsum_ff[c] <= colsum[c];
         end
      end
   end

   // Stage 3: window sum, sample count and the rounding numerator.
   always_comb begin
      sum = eabf_pkg::SUM_W'(colsum_ff[1])
          + (s3_edge_ff.right_ok ? eabf_pkg::SUM_W'(colsum_ff[0]) : '0)
          + (s3_edge_ff.left_ok ? eabf_pkg::SUM_W'(colsum_ff[2]) : '0);
      rows  = 2'(1) + 2'(s3_edge_ff.top_ok) + 2'(s3_edge_ff.bottom_ok);
      cols  = 2'(1) + 2'(s3_edge_ff.left_ok) + 2'(s3_edge_ff.right_ok);
      count = eabf_pkg::COUNT_W'(rows) * eabf_pkg::COUNT_W'(cols);
      num   = (eabf_pkg::NUM_W'(sum) << 1) + eabf_pkg::NUM_W'(count);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         n_ff       <= num;
         m_ff       <= eabf_pkg::recip_of_count(count);
         s4_last_ff <= s3_edge_ff.last;
      end
   end

   // Stage 4: divide by 2*count through the reciprocal.
   assign product = eabf_pkg::PROD_W'(n_ff) * eabf_pkg::PROD_W'(m_ff);

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && s4_valid_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s4_valid_ff) begin
         rsp_height_ff <= product[eabf_pkg::RECIP_SHIFT +: SW];
         rsp_last_ff   <= s4_last_ff;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.smoothed_height = rsp_height_ff;
   assign rsp_chan.frame_last      = rsp_last_ff;

   // A stalled last stage keeps its operands.
   `EABF_ASSERT_NEXT(a_stall_holds, clock, reset, s4_valid_ff && rsp_valid_ff && !rsp_chan.ready, s4_valid_ff && $stable(n_ff) && $stable(m_ff))

   // A word that does not shift the window leaves no pipeline entry.
   `EABF_ASSERT_NEXT(a_drop_no_entry, clock, reset, accept && !take, !s1_valid_ff)

   // The end-of-frame result returns the counters to the frame start.
   `EABF_ASSERT_NEXT(a_frame_end_clears, clock, reset, accept && take && emit_now && edge_now.last, in_row_ff == '0 && in_column_ff == '0 && !primed_ff)

   // Every result carries a valid sample count.
   `EABF_ASSERT_IMP(a_count_valid, clock, reset, s4_valid_ff, m_ff != '0)

endmodule

// ===== verif/tb_edge_aware_box_filter_3x3.sv =====
// ----------------------------------------------------------------------
// Edge-aware 3x3 box filter testbench
// Streams height grids of many shapes through the filter with random
// gaps on both channels. A behavioral copy of the filter predicts every
// smoothed word, and each word that comes out is checked in order.
// ----------------------------------------------------------------------
module tb_edge_aware_box_filter_3x3;

   localparam int LINE_DEPTH     = eabf_pkg::MAX_WIDTH_DEFAULT;
   localparam int SW             = eabf_pkg::SAMPLE_W;
   localparam int DW             = eabf_pkg::CSR_DATA_W;
   localparam int SETTLE_CYCLES  = 12;
   localparam int TAIL_CYCLES    = 16;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_WORDS   = 640;

   typedef struct packed {
      logic [SW-1:0] smoothed_height;
      logic          frame_last;
   } smoothed_word_type;

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               csr_write_enable;
   logic [eabf_pkg::CSR_INDEX_W-1:0]   csr_index;
   logic [DW-1:0]                      csr_write_data;

   eabf_req_if req_bus ();
   eabf_rsp_if rsp_bus ();

   edge_aware_box_filter_3x3 u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Clock with a period of four units.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow copy of the filter: configuration, line stores, window, counters.
   logic [eabf_pkg::GRID_WIDTH_W-1:0]  cfg_width  = eabf_pkg::GRID_WIDTH_RESET;
   logic [eabf_pkg::GRID_HEIGHT_W-1:0] cfg_height = eabf_pkg::GRID_HEIGHT_RESET;
   logic [SW-1:0]            older_line [LINE_DEPTH];
   logic [SW-1:0]            newer_line [LINE_DEPTH];
   logic [SW-1:0]            window [3][3];
   int unsigned              in_col, in_row, out_col, out_row;
   bit                       primed_q;

   smoothed_word_type smoothed_due [$];
   int unsigned    mismatch_count = 0;
   int unsigned    stalled_cycles = 0;
   int unsigned    stall_left = 0;
   int unsigned    words_counted = 0;
   bit             calm_mode = 1'b0;

   // The stores start at zero; entries never written only reach cells that
   // the edge masks drop, so their value does not matter.
   initial begin
      for (int i = 0; i < LINE_DEPTH; i++) begin
         older_line[i] = '0;
         newer_line[i] = '0;
      end
      for (int c = 0; c < 3; c++) begin
         for (int r = 0; r < 3; r++) begin
            window[c][r] = '0;
         end
      end
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      primed_q = 1'b0;
   end

   // Width register: zero acts as one, anything past the stores as full depth.
   function automatic int unsigned effective_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > LINE_DEPTH) return LINE_DEPTH;
      return cfg_width;
   endfunction

   function automatic int unsigned effective_height();
      return (cfg_height == 0) ? 1 : cfg_height;
   endfunction

   // Shift a new column into the window; column 0 is the newest.
   task automatic shift_window(input logic [SW-1:0] incoming);
      int unsigned   idx;
      logic [SW-1:0] top, mid;
      idx = (in_col < LINE_DEPTH) ? in_col : LINE_DEPTH - 1;
      top = older_line[idx];
      mid = newer_line[idx];
      window[2] = window[1];
      window[1] = window[0];
      window[0][0] = top;
      window[0][1] = mid;
      window[0][2] = incoming;
      older_line[idx] = mid;
      newer_line[idx] = incoming;
   endtask

   // Rounded mean of the in-bounds cells around the window center.
   task automatic emit_smoothed(input int unsigned w, input int unsigned h);
      bit                row_ok [3];
      bit                col_ok [3];
      int unsigned       sum, count;
      smoothed_word_type word;
      row_ok[0] = out_row > 0;
      row_ok[1] = 1'b1;
      row_ok[2] = out_row + 1 < h;
      col_ok[2] = out_col > 0;
      col_ok[1] = 1'b1;
      col_ok[0] = out_col + 1 < w;
      sum = 0;
      count = 0;
      for (int c = 0; c < 3; c++) begin
         for (int r = 0; r < 3; r++) begin
            if (row_ok[r] && col_ok[c]) begin
               sum += window[c][r];
               count++;
            end
         end
      end
      word.smoothed_height = SW'((2 * sum + count) / (2 * count));
      word.frame_last = (out_row + 1 >= h) && (out_col + 1 >= w);
      smoothed_due = {smoothed_due, word};
      if (word.frame_last) begin
         in_col = 0;
         in_row = 0;
         out_col = 0;
         out_row = 0;
         primed_q = 1'b0;
      end else if (out_col + 1 >= w) begin
         out_col = 0;
         out_row++;
      end else begin
         out_col++;
      end
   endtask

   // Update the shadow filter with one accepted word.
   task automatic predict_word(input logic [SW-1:0] sample, input logic drain);
      int unsigned w, h;
      bit          was_primed;
      w = effective_width();
      h = effective_height();
      was_primed = primed_q;
      if (in_row < h) begin
         // Sample phase: drain words are dropped; a sample from the second
         // row on primes the output.
         if (drain) return;
         if (in_row >= 1) primed_q = 1'b1;
         shift_window(sample);
         if (in_col + 1 >= w) begin
            in_col = 0;
            in_row++;
         end else begin
            in_col++;
         end
         if (was_primed) emit_smoothed(w, h);
      end else begin
         // Flush phase: samples are dropped, drains push a zero sample.
         if (!drain) return;
         shift_window('0);
         in_col = (in_col + 1 >= w) ? 0 : in_col + 1;
         if (!was_primed) primed_q = 1'b1;
         else emit_smoothed(w, h);
      end
   endtask

   // Mostly back to back, sometimes a short gap, rarely a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (calm_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 62) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [SW-1:0] pick_height(input int unsigned style);
      case (style)
         1: return SW'(16'hFFFF - $urandom_range(0, 31));
         2: return SW'($urandom_range(0, 31));
         default: return SW'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   // Offer one word and wait for the handshake.
   task automatic send_word(input logic [SW-1:0] sample, input logic drain);
      int unsigned gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.height_sample <= sample;
      req_bus.drain <= drain;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_word(sample, drain);
   endtask

   task automatic idle_sender();
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   task automatic wait_results_drained();
      while (smoothed_due.size() != 0) @(posedge clock);
   endtask

   // Let the pipeline empty out before touching the registers.
   task automatic settle_block();
      idle_sender();
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [eabf_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [DW-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (index == eabf_pkg::CSR_GRID_WIDTH) cfg_width = data[eabf_pkg::GRID_WIDTH_W-1:0];
      else cfg_height = data[eabf_pkg::GRID_HEIGHT_W-1:0];
   endtask

   // Unused upper bits of the width write carry random junk.
   task automatic configure_grid(input int unsigned width_value,
                                 input int unsigned height_value);
      logic [DW-1:0] width_data;
      settle_block();
      width_data = DW'(width_value);
      width_data[DW-1:eabf_pkg::GRID_WIDTH_W] =
         (DW - eabf_pkg::GRID_WIDTH_W)'($urandom_range(0, 7));
      write_register(eabf_pkg::CSR_GRID_WIDTH, width_data);
      write_register(eabf_pkg::CSR_GRID_HEIGHT, DW'(height_value));
   endtask

   // One whole frame: samples, then width+1 drains, with optional stray words.
   task automatic run_frame(input bit noise_on, input int pause_at);
      int          w, h;
      int unsigned style;
      w = effective_width();
      h = effective_height();
      style = $urandom_range(0, 3);
      for (int n = 0; n < w * h; n++) begin
         if (noise_on && $urandom_range(0, 99) < 8) begin
            send_word(SW'($urandom_range(0, 16'hFFFF)), 1'b1);
         end
         if (n == pause_at) begin
            idle_sender();
            wait_results_drained();
         end
         send_word(pick_height(style), 1'b0);
         words_counted++;
      end
      for (int n = 0; n <= w; n++) begin
         if (noise_on && n < w && $urandom_range(0, 99) < 8) begin
            send_word(SW'($urandom_range(0, 16'hFFFF)), 1'b0);
         end
         send_word(SW'($urandom_range(0, 16'hFFFF)), 1'b1);
         words_counted++;
      end
      // A drain after the frame has ended starts nothing.
      if (noise_on && $urandom_range(0, 99) < 10) begin
         send_word(SW'($urandom_range(0, 16'hFFFF)), 1'b1);
      end
   endtask

   // Corners, edges, the interior, one-sample grids and stray words.
   task automatic test_directed_corners();
      logic [SW-1:0] corner_heights [9];
      corner_heights = '{16'd0, 16'hFFFF, 16'd1, 16'hFFFF, 16'd0, 16'hFFFE,
                         16'h8000, 16'd7, 16'hFFFF};
      configure_grid(3, 3);
      send_word(16'hFFFF, 1'b1);
      for (int i = 0; i < 9; i++) send_word(corner_heights[i], 1'b0);
      send_word(16'h5A5A, 1'b0);
      repeat (4) send_word(16'hFFFF, 1'b1);
      configure_grid(1, 1);
      send_word(16'hFFFF, 1'b0);
      repeat (2) send_word(16'd0, 1'b1);
      // Two samples whose mean sits exactly on a half.
      configure_grid(2, 1);
      send_word(16'd0, 1'b0);
      send_word(16'd1, 1'b0);
      repeat (3) send_word(16'd0, 1'b1);
   endtask

   // Many small random frames with stray words; the first one pauses mid-way.
   task automatic test_random_frames();
      int unsigned w, h, pick;
      bit          first;
      first = 1'b1;
      words_counted = 0;
      while (words_counted < RANDOM_WORDS) begin
         pick = $urandom_range(0, 99);
         w = (pick < 70) ? $urandom_range(1, 8) :
             (pick < 95) ? $urandom_range(9, 24) : $urandom_range(25, 64);
         h = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 12);
         configure_grid(w, h);
         calm_mode = ($urandom_range(0, 4) == 0);
         run_frame(1'b1, first ? int'($urandom_range(0, w * h - 1)) : -1);
         first = 1'b0;
      end
      calm_mode = 1'b0;
   endtask

   // Register extremes: zero values and grids one sample wide or one row high.
   task automatic test_geometry_extremes();
      configure_grid(0, 0);
      run_frame(1'b1, -1);
      configure_grid(1, 2);
      run_frame(1'b1, -1);
      configure_grid(0, 3);
      run_frame(1'b1, -1);
      configure_grid(5, 0);
      run_frame(1'b0, -1);
      configure_grid(1, 12);
      run_frame(1'b0, -1);
   endtask

   // Result side: ready drops for random stretches.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   // Compare each accepted result word with the oldest prediction.
   always @(posedge clock) begin : check_results
      smoothed_word_type due;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (smoothed_due.size() == 0) begin
            $display("%0t: unexpected result height=%0d last=%0b", $time,
                     rsp_bus.smoothed_height, rsp_bus.frame_last);
            mismatch_count++;
         end else begin
            due = smoothed_due.pop_front();
            if (rsp_bus.smoothed_height !== due.smoothed_height) begin
               $display("%0t: smoothed_height expected %0d actual %0d", $time,
                        due.smoothed_height, rsp_bus.smoothed_height);
               mismatch_count++;
            end
            if (rsp_bus.frame_last !== due.frame_last) begin
               $display("%0t: frame_last expected %0b actual %0b", $time,
                        due.frame_last, rsp_bus.frame_last);
               mismatch_count++;
            end
         end
      end
   end

   // Stop the run when no word moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         stalled_cycles = 0;
      end else begin
         stalled_cycles++;
         if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no handshake for %0d cycles", $time, stalled_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Reset, run the tests in turn, then wait out the pipeline.
   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.height_sample = '0;
      req_bus.drain = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = eabf_pkg::CSR_GRID_WIDTH;
      csr_write_data = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_corners();
      test_random_frames();
      test_geometry_extremes();
      idle_sender();
      wait_results_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/eabf_pkg.sv
rtl/eabf_if.sv
rtl/edge_aware_box_filter_3x3.sv
verif/tb_edge_aware_box_filter_3x3.sv
